FILE: design/lapf_pkg.sv
`timescale 1ns / 1ps

package lapf_pkg;

	localparam int PIX_W        = 8;
	localparam int WIDTH_CFG_W  = 10;
	localparam int HEIGHT_CFG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam int RESET_WIDTH  = 512;
	localparam int RESET_HEIGHT = 512;

	// Result queue depth; a power of two.
	localparam int OUT_FIFO_DEPTH = 8;

	typedef struct packed {
		logic [PIX_W-1:0] filtered;
		logic             end_of_row;
		logic             end_of_frame;
	} lapf_result_t;

	// Up to two results leave the window stage per beat.
	typedef struct packed {
		logic         push_a;
		logic         push_b;
		lapf_result_t res_a;
		lapf_result_t res_b;
	} lapf_push_t;

	// 4*center minus the four neighbors, clipped to 0..255.
	function automatic logic [PIX_W-1:0] lap_sat(
		input logic [PIX_W-1:0] top,
		input logic [PIX_W-1:0] left,
		input logic [PIX_W-1:0] center,
		input logic [PIX_W-1:0] right,
		input logic [PIX_W-1:0] low
	);
		logic [11:0] pos;
		logic [11:0] neg;
		logic [11:0] diff;
		logic [PIX_W-1:0] res;
		pos  = {2'b00, center, 2'b00};
		neg  = 12'(top) + 12'(left) + 12'(right) + 12'(low);
		diff = pos - neg;
		if (neg > pos) begin
			res = '0;
		end else if (diff > 12'd255) begin
			res = '1;
		end else begin
			res = diff[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

FILE: design/lapf_ram.sv
`timescale 1ns / 1ps

module lapf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/lapf_window.sv
`timescale 1ns / 1ps

module lapf_window
	import lapf_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [PIX_W-1:0]      pixel,
	output lapf_push_t            push
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
	localparam int LINE_W = 2 * PIX_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] wlast_q;
	logic [ROW_W-1:0] hgt_q;

	logic [WIDTH_CFG_W-1:0]  wval;
	logic [HEIGHT_CFG_W-1:0] hval;
	logic [COL_W-1:0]        wlast_new;
	logic [ROW_W-1:0]        hgt_new;

	logic              is_last;
	logic [COL_W-1:0]  col_nxt;
	logic [ROW_W-1:0]  row_nxt;
	logic [COL_W-1:0]  rd_addr;
	logic [LINE_W-1:0] ram_q;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] line_wr;
	logic              fwd_q;
	logic [LINE_W-1:0] fwd_data_q;
	logic [PIX_W-1:0]  top_pix;
	logic [PIX_W-1:0]  mid_raw;
	logic [PIX_W-1:0]  mid_pix;
	logic [PIX_W-1:0]  low_pix;

	logic [PIX_W-1:0] win_top1_q, win_top2_q;
	logic [PIX_W-1:0] win_mid0_q, win_mid1_q, win_mid2_q;
	logic [PIX_W-1:0] win_low1_q, win_low2_q;
	logic             emit_a_s1, emit_b_s1, eof_s1;

	// Register values outside their range are clamped once, at write time.
	always_comb begin
		wval = cfg_data[WIDTH_CFG_W-1:0];
		hval = cfg_data[HEIGHT_CFG_W-1:0];
		if (wval == '0) begin
			wlast_new = '0;
		end else if (32'(wval) > 32'(MAX_WIDTH)) begin
			wlast_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			wlast_new = COL_W'(32'(wval) - 32'd1);
		end
		if (hval == '0) begin
			hgt_new = ROW_W'(1);
		end else if (32'(hval) > 32'(MAX_HEIGHT)) begin
			hgt_new = ROW_W'(MAX_HEIGHT);
		end else begin
			hgt_new = ROW_W'(hval);
		end
	end

	assign is_last = (col_q == wlast_q);
	assign col_nxt = is_last ? '0 : col_q + COL_W'(1);
	assign row_nxt = !is_last ? row_q : ((row_q == hgt_q) ? '0 : row_q + ROW_W'(1));

	// Each line entry holds {row two above, row just above}. The read runs one
	// beat ahead; a one-pixel row reads the entry it is writing, so forward it.
	assign rd_addr = cfg_write ? '0 : (accept ? col_nxt : col_q);
	assign line_rd = fwd_q ? fwd_data_q : ram_q;
	assign mid_raw = line_rd[PIX_W-1:0];
	assign top_pix = (row_q > ROW_W'(1)) ? line_rd[LINE_W-1:PIX_W] : '0;
	assign mid_pix = (row_q != '0) ? mid_raw : '0;
	assign low_pix = (row_q != hgt_q) ? pixel : '0;
	assign line_wr = {mid_raw, low_pix};

	lapf_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH),
		.AW    (COL_W)
	) u_line_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (line_wr),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			wlast_q   <= COL_W'(RST_W - 1);
			hgt_q     <= ROW_W'(RST_H);
			fwd_q     <= 1'b0;
			emit_a_s1 <= 1'b0;
			emit_b_s1 <= 1'b0;
		end else begin
			fwd_q     <= accept && (col_nxt == col_q);
			emit_a_s1 <= accept && (row_q != '0) && (col_q != '0);
			emit_b_s1 <= accept && (row_q != '0) && is_last;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  wlast_q <= wlast_new;
					REG_FRAME_HEIGHT: hgt_q   <= hgt_new;
					default:          ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= line_wr;
		if (accept) begin
			eof_s1 <= (row_q == hgt_q);
			if (col_q == '0) begin
				// Left edge: the first column is repeated across the window.
				win_top1_q <= top_pix;
				win_top2_q <= top_pix;
				win_mid0_q <= mid_pix;
				win_mid1_q <= mid_pix;
				win_mid2_q <= mid_pix;
				win_low1_q <= low_pix;
				win_low2_q <= low_pix;
			end else begin
				win_top1_q <= win_top2_q;
				win_top2_q <= top_pix;
				win_mid0_q <= win_mid1_q;
				win_mid1_q <= win_mid2_q;
				win_mid2_q <= mid_pix;
				win_low1_q <= win_low2_q;
				win_low2_q <= low_pix;
			end
		end
	end

	// The end-of-row result centers on the newest column and repeats it as
	// its right neighbor.
	always_comb begin
		push.push_a             = emit_a_s1;
		push.push_b             = emit_b_s1;
		push.res_a.filtered     = lap_sat(win_top1_q, win_mid0_q, win_mid1_q, win_mid2_q,
			win_low1_q);
		push.res_a.end_of_row   = 1'b0;
		push.res_a.end_of_frame = 1'b0;
		push.res_b.filtered     = lap_sat(win_top2_q, win_mid1_q, win_mid2_q, win_mid2_q,
			win_low2_q);
		push.res_b.end_of_row   = 1'b1;
		push.res_b.end_of_frame = eof_s1;
	end

endmodule

FILE: design/lapf_out_fifo.sv
`timescale 1ns / 1ps

module lapf_out_fifo
	import lapf_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  lapf_push_t   push,
	input  logic         out_ready,
	output logic         out_valid,
	output lapf_result_t out_data,
	output logic         space_ok
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lapf_result_t     mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       n_push;
	logic             pop;
	lapf_result_t     first;

	assign n_push    = 2'(push.push_a) + 2'(push.push_b);
	assign first     = push.push_a ? push.res_a : push.res_b;
	assign out_valid = (count_q != '0);
	assign out_data  = mem[rd_q];
	assign pop       = out_valid && out_ready;

	// A new beat may produce two results; leave room for them on top of what
	// is already queued or still in the window stage.
	assign space_ok = (32'(count_q) + 32'(n_push)) <= 32'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.push_a || push.push_b) begin
			mem[wr_q] <= first;
		end
		if (push.push_a && push.push_b) begin
			mem[wr_q + PTR_W'(1)] <= push.res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(n_push);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

FILE: design/laplacian_3x3_stream_filter.sv
`timescale 1ns / 1ps
// The result for pixel (r,c) is formed once the input beat at (r+1,c+1) is accepted,
// or the beat at (r+1,last column) for a row's end, and is queued after the window stage.
// Throughput: one input beat per cycle, sustained; the input stalls only when held-back
// results, counting those still in the window stage, leave under two free queue entries.
// Reset clears the frame position and the result queue and restores a 512x512 frame.
// The line buffer RAM is not cleared; rows 0 and 1 never read stale entries.

module laplacian_3x3_stream_filter
	import lapf_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      filtered,
	output logic                  end_of_row,
	output logic                  end_of_frame
);

	lapf_push_t   push;
	lapf_result_t out_data;
	logic         accept;

	assign accept = in_valid && in_ready;

	lapf_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pixel     (pixel),
		.push      (push)
	);

	lapf_out_fifo #(
		.DEPTH (OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.space_ok  (in_ready)
	);

	assign filtered     = out_data.filtered;
	assign end_of_row   = out_data.end_of_row;
	assign end_of_frame = out_data.end_of_frame;

endmodule

FILE: design/lapf_checker.sv
`timescale 1ns / 1ps

module lapf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] filtered,
	input logic       end_of_row,
	input logic       end_of_frame
);

	// A result beat that is held back stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(filtered) && $stable(end_of_row) && $stable(end_of_frame))
		else $error("output beat changed while stalled");

	// The last pixel of the image is always also the last of its row.
	a_eof_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_row)
		else $error("end_of_frame without end_of_row");

	// The input only stalls when results are waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind laplacian_3x3_stream_filter lapf_checker u_lapf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.filtered     (filtered),
	.end_of_row   (end_of_row),
	.end_of_frame (end_of_frame)
);

FILE: tb/laplacian_3x3_stream_filter_tb.sv
`timescale 1ns / 1ps

module laplacian_3x3_stream_filter_tb;
	import lapf_pkg::*;

	localparam int MAX_W = 512;
	localparam int MAX_H = 4096;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_TARGET = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] pixel = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PIX_W-1:0] filtered;
	logic end_of_row;
	logic end_of_frame;

	laplacian_3x3_stream_filter #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered(filtered),
		.end_of_row(end_of_row),
		.end_of_frame(end_of_frame)
	);

	// Pixels still to be offered, and results the filter still owes.
	logic [PIX_W-1:0] pixel_backlog [$];
	lapf_result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	int beat_count = 0;
	int result_count = 0;
	int mismatch_count = 0;
	int setting_count = 0;

	// Mirror of the filter: frame size, line stores, window and position.
	logic [WIDTH_CFG_W-1:0] cur_width = WIDTH_CFG_W'(RESET_WIDTH);
	logic [HEIGHT_CFG_W-1:0] cur_height = HEIGHT_CFG_W'(RESET_HEIGHT);
	logic [PIX_W-1:0] upper_buf [MAX_W];
	logic [PIX_W-1:0] middle_buf [MAX_W];
	logic [PIX_W-1:0] win [9] = '{default: '0};
	int row_pos = 0;
	int col_pos = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("laplacian_3x3_stream_filter_tb NOT OK");
		$finish;
	end

	function automatic int eff_width();
		if (cur_width == 0)
			return 1;
		return (cur_width > MAX_W) ? MAX_W : int'(cur_width);
	endfunction

	function automatic int eff_height();
		if (cur_height == 0)
			return 1;
		return (cur_height > MAX_H) ? MAX_H : int'(cur_height);
	endfunction

	task automatic shift_window(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] d);
		for (int k = 0; k < 3; k++) begin
			win[3*k] = win[3*k+1];
			win[3*k+1] = win[3*k+2];
		end
		win[2] = a;
		win[5] = b;
		win[8] = d;
	endtask

	task automatic emit_laplacian(input logic eor, input logic eof);
		int s;
		lapf_result_t res;
		s = 4 * int'(win[4]) - int'(win[1]) - int'(win[7]) - int'(win[3]) - int'(win[5]);
		if (s < 0)
			s = 0;
		if (s > 255)
			s = 255;
		res.filtered = PIX_W'(s);
		res.end_of_row = eor;
		res.end_of_frame = eof;
		pending_results.push_back(res);
	endtask

	task automatic predict_pixel(input logic [PIX_W-1:0] pix);
		int w;
		int h;
		int r;
		int c;
		logic [PIX_W-1:0] lower;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] top;
		w = eff_width();
		h = eff_height();
		r = (row_pos > h) ? h : row_pos;
		c = (col_pos >= w) ? w - 1 : col_pos;
		// The filler row after the last image row reads as black.
		lower = (r < h) ? pix : '0;
		top = (r >= 2) ? upper_buf[c] : '0;
		mid = (r >= 1) ? middle_buf[c] : '0;
		upper_buf[c] = middle_buf[c];
		middle_buf[c] = lower;
		if (c == 0) begin
			win = '{top, top, top, mid, mid, mid, lower, lower, lower};
		end else begin
			shift_window(top, mid, lower);
		end
		if (r >= 1) begin
			if (c >= 1)
				emit_laplacian(1'b0, 1'b0);
			if (c == w - 1) begin
				// Past the right edge the last column repeats.
				if (w > 1)
					shift_window(win[2], win[5], win[8]);
				emit_laplacian(1'b1, r == h);
			end
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// Sender: offers the backlog one beat at a time, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel <= '0;
		end else if (!in_valid || in_ready) begin
			if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				pixel <= pixel_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_ack <= 0;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		lapf_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_pixel(pixel);
				beat_count++;
			end
			if (out_valid && out_ready) begin
				result_count++;
				if (pending_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result %0d: filtered=%0d eor=%0b eof=%0b",
							result_count, filtered, end_of_row, end_of_frame);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (filtered !== want.filtered || end_of_row !== want.end_of_row ||
							end_of_frame !== want.end_of_frame) begin
						if (mismatch_count < 10)
							$display({"result %0d: expected filtered=%0d eor=%0b eof=%0b,",
								" got filtered=%0d eor=%0b eof=%0b"}, result_count,
								want.filtered, want.end_of_row, want.end_of_frame,
								filtered, end_of_row, end_of_frame);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Returns once every pixel is taken and every result has come back.
	task automatic wait_quiet();
		while (pixel_backlog.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		wait_quiet();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		if (idx == REG_FRAME_WIDTH)
			cur_width = WIDTH_CFG_W'(value);
		else
			cur_height = HEIGHT_CFG_W'(value);
		// Any write starts a new frame.
		row_pos = 0;
		col_pos = 0;
		setting_count++;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_idle(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic queue_random(input int count);
		logic [PIX_W-1:0] v;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(7))
				0: v = '0;
				1: v = '1;
				default: v = PIX_W'($urandom_range(255));
			endcase
			pixel_backlog.push_back(v);
		end
	endtask

	initial begin
		int idle_send [4];
		int idle_stall [4];
		int random_beats;
		int choice;
		int frame_len;
		int frames;
		int grp;
		idle_send = '{0, 67, 0, 33};
		idle_stall = '{0, 0, 67, 33};
		random_beats = 0;
		grp = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: saturation both ways, filler row ignored, tiny and clamped sizes.
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 2);
		pixel_backlog = {8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd91, 8'd180, 8'd7};
		write_reg(REG_FRAME_WIDTH, 1);
		write_reg(REG_FRAME_HEIGHT, 1);
		// Two frames back to back check the wrap after the filler row.
		pixel_backlog = {8'd255, 8'd200, 8'd0, 8'd13};
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 3);
		pixel_backlog = {8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd1, 8'd9, 8'd9};
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 0);
		pixel_backlog = {8'd255, 8'd255};

		// Largest sizes: an oversized width clamps to the limit, and a tall frame
		// is cut short by the next write.
		write_reg(REG_FRAME_WIDTH, 1023);
		write_reg(REG_FRAME_HEIGHT, 1);
		queue_random(2 * MAX_W);
		set_idle(33, 33);
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 8191);
		queue_random(200);

		// Long output hold-off while the sender keeps pushing.
		set_idle(0, 0);
		write_reg(REG_FRAME_WIDTH, 8);
		write_reg(REG_FRAME_HEIGHT, 30);
		hold_req++;
		queue_random(8 * 31);

		while (random_beats < RANDOM_TARGET) begin
			wait_quiet();
			set_idle(idle_send[grp % 4], idle_stall[grp % 4]);
			grp++;
			choice = $urandom_range(2);
			if (choice != 1) begin
				case ($urandom_range(19))
					0: write_reg(REG_FRAME_WIDTH, 0);
					1: write_reg(REG_FRAME_WIDTH, $urandom_range(1023, 480));
					2, 3, 4: write_reg(REG_FRAME_WIDTH, $urandom_range(80, 17));
					default: write_reg(REG_FRAME_WIDTH, $urandom_range(16, 1));
				endcase
			end
			if (choice != 0) begin
				if ($urandom_range(9) == 0)
					write_reg(REG_FRAME_HEIGHT, $urandom_range(40, 9));
				else
					write_reg(REG_FRAME_HEIGHT, $urandom_range(8));
			end
			frame_len = eff_width() * (eff_height() + 1);
			frames = (frame_len > 600) ? 0 : 1 + $urandom_range(2);
			queue_random(frames * frame_len);
			random_beats += frames * frame_len;
			// A partial frame leaves the next register write to land mid-frame.
			if (frames == 0 || $urandom_range(3) == 0) begin
				frame_len = (frame_len - 1 > 600) ? 600 : frame_len - 1;
				frame_len = $urandom_range(frame_len, 1);
				queue_random(frame_len);
				random_beats += frame_len;
			end
		end

		wait_quiet();
		$display("Run covered %0d pixel beats and %0d filtered results over %0d register writes,",
			beat_count, result_count, setting_count);
		$display("with clamped frame sizes, mid-frame restarts, a long output hold and %0d errors.",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("laplacian_3x3_stream_filter_tb OK");
		end else begin
			$display("laplacian_3x3_stream_filter_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: laplacian_3x3_stream_filter.f
design/lapf_pkg.sv
design/lapf_ram.sv
design/lapf_window.sv
design/lapf_out_fifo.sv
design/laplacian_3x3_stream_filter.sv
design/lapf_checker.sv
tb/laplacian_3x3_stream_filter_tb.sv
